>>> rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and codes of the linear-probing hash table core.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned HASH_W  = 32;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned LIMIT_W = 6;

  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 6'd48;

  typedef enum logic [1:0] {
    REQ_GET = 2'd0,
    REQ_SET = 2'd1,
    REQ_DEL = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    RSP_OK   = 2'd0,
    RSP_NEW  = 2'd1,
    RSP_MISS = 2'd2,
    RSP_FULL = 2'd3
  } rsp_status_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_state_e;

  typedef struct packed {
    slot_state_e       state;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } slot_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_PROBE = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

endpackage

>>> rtl/lpht_if.sv
// ----------------------------------------------------------------------------
// lpht interfaces
// Request, response and configuration channels of the hash table core.
// ----------------------------------------------------------------------------
interface lpht_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [lpht_pkg::KEY_W-1:0]  key_id;
  logic [lpht_pkg::HASH_W-1:0] key_hash;
  logic [lpht_pkg::VAL_W-1:0]  value_in;

  modport source (output valid, req_type, key_id, key_hash, value_in, input ready);
  modport sink   (input valid, req_type, key_id, key_hash, value_in, output ready);
endinterface

interface lpht_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [lpht_pkg::VAL_W-1:0] value_out;

  modport source (output valid, status, value_out, input ready);
  modport sink   (input valid, status, value_out, output ready);
endinterface

interface lpht_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lpht_pkg::LIMIT_W-1:0] load_limit;

  modport source (output valid, load_limit, input ready);
  modport sink   (input valid, load_limit, output ready);
endinterface

>>> rtl/linear_probe_hash_table_core.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressing key/value table with linear probing and tombstones.
// ----------------------------------------------------------------------------
//
//   channel  dir  transfer when    payload
//   req_i    in   valid && ready   req_type, key_id, key_hash, value_in
//   rsp_o    out  valid && ready   status, value_out
//   cfg_i    in   valid && ready   load_limit (always ready)
//
// a request goes through accept, hash reduction (one byte a cycle), P slot
// reads (one per probe, 1 <= P <= SLOTS) and the result cycle.
// empty-table gets and deletes and unknown types go straight to the result.
// the memory read port sets the probe pace: one slot read per cycle.
// after reset a clearing pass marks all SLOTS entries empty, with req_i
// not ready. a stalled result waits in the output register while
// the next request is taken; it only holds the core in the result cycle.
module linear_probe_hash_table_core #(
  parameter int unsigned SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpht_req_if.sink    req_i,
  lpht_cfg_if.sink    cfg_i,
  lpht_rsp_if.source  rsp_o
);

  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned FILL_W = $clog2(SLOTS + 1);
  localparam int unsigned CMP_W  = (FILL_W + 1 > lpht_pkg::LIMIT_W) ?
                                   FILL_W + 1 : lpht_pkg::LIMIT_W;
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(SLOTS - 1);

  lpht_pkg::state_e             state_q, state_d;
  logic [IDX_W-1:0]             idx_q, idx_d, idx_inc;
  logic [IDX_W-1:0]             cnt_q, cnt_d;
  logic [IDX_W-1:0]             tomb_q, tomb_d, tomb_now;
  logic                         have_tomb_q, have_tomb_d, have_now;
  logic [FILL_W-1:0]            fill_q, fill_d;
  logic [lpht_pkg::LIMIT_W-1:0] limit_q;

  logic [1:0]                   req_q;
  logic [lpht_pkg::KEY_W-1:0]   key_q;
  logic [lpht_pkg::VAL_W-1:0]   val_q;

  lpht_pkg::rsp_status_e        res_status_q, res_status_d;
  logic [lpht_pkg::VAL_W-1:0]   res_value_q, res_value_d;

  logic                         rsp_valid_q;
  lpht_pkg::rsp_status_e        rsp_status_q;
  logic [lpht_pkg::VAL_W-1:0]   rsp_value_q;
  logic                         out_free;

  lpht_pkg::slot_t              slot_mem_q [SLOTS];
  lpht_pkg::slot_t              rdata_q;
  lpht_pkg::slot_t              wdata;
  logic [IDX_W-1:0]             waddr;
  logic                         we;

  logic                         req_xfer, skip, mod_start, mod_done;
  logic [IDX_W-1:0]             mod_idx;
  logic                         hit_key, is_tomb, is_empty, last, fits;

  lpht_hash_mod #(
    .SLOTS (SLOTS)
  ) u_hash_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .hash_i  (req_i.key_hash),
    .done_o  (mod_done),
    .idx_o   (mod_idx)
  );

  assign req_i.ready = (state_q == lpht_pkg::S_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free    = !rsp_valid_q || rsp_o.ready;

  assign skip = !((req_i.req_type == lpht_pkg::REQ_GET) ||
                  (req_i.req_type == lpht_pkg::REQ_SET) ||
                  (req_i.req_type == lpht_pkg::REQ_DEL)) ||
                ((req_i.req_type != lpht_pkg::REQ_SET) && (fill_q == '0));

  // probe decode on the slot read last cycle (rdata_q belongs to idx_q)
  assign hit_key  = (rdata_q.state == lpht_pkg::SLOT_USED) && (rdata_q.key == key_q);
  assign is_tomb  = (rdata_q.state == lpht_pkg::SLOT_TOMB);
  assign is_empty = (rdata_q.state != lpht_pkg::SLOT_USED) && !is_tomb;
  assign last     = (cnt_q == LastIdx);
  assign tomb_now = have_tomb_q ? tomb_q : idx_q;
  assign have_now = have_tomb_q || is_tomb;
  assign idx_inc  = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
  assign fits     = (CMP_W'(fill_q) + 1'b1) <= CMP_W'(limit_q);

  always_comb begin
    logic found, use_tomb, use_empty;
    state_d      = state_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    tomb_d       = tomb_q;
    have_tomb_d  = have_tomb_q;
    fill_d       = fill_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    mod_start    = 1'b0;
    we           = 1'b0;
    waddr        = idx_q;
    wdata.state  = lpht_pkg::SLOT_EMPTY;
    wdata.key    = '0;
    wdata.value  = '0;
    found        = 1'b0;
    use_tomb     = 1'b0;
    use_empty    = 1'b0;

    unique case (state_q)
      lpht_pkg::S_CLEAR: begin
        we    = 1'b1;
        idx_d = idx_inc;
        if (idx_q == LastIdx) begin
          state_d = lpht_pkg::S_IDLE;
        end
      end
      lpht_pkg::S_IDLE: begin
        if (req_xfer) begin
          res_status_d = lpht_pkg::RSP_MISS;
          res_value_d  = '0;
          if (skip) begin
            state_d = lpht_pkg::S_RESP;
          end else begin
            mod_start = 1'b1;
            state_d   = lpht_pkg::S_HASH;
          end
        end
      end
      lpht_pkg::S_HASH: begin
        cnt_d       = '0;
        have_tomb_d = 1'b0;
        if (mod_done) begin
          idx_d   = mod_idx;
          state_d = lpht_pkg::S_PROBE;
        end
      end
      lpht_pkg::S_PROBE: begin
        if (hit_key) begin
          found = 1'b1;
        end else if (is_empty) begin
          use_tomb  = have_tomb_q;
          use_empty = !have_tomb_q;
        end else if (last) begin
          use_tomb = have_now;
        end

        if (hit_key || is_empty || last) begin
          state_d = lpht_pkg::S_RESP;
          case (req_q)
            lpht_pkg::REQ_GET: begin
              if (found) begin
                res_status_d = lpht_pkg::RSP_OK;
                res_value_d  = rdata_q.value;
              end
            end
            lpht_pkg::REQ_SET: begin
              wdata.state = lpht_pkg::SLOT_USED;
              wdata.key   = key_q;
              wdata.value = val_q;
              if (found) begin
                we           = 1'b1;
                res_status_d = lpht_pkg::RSP_OK;
              end else if (use_tomb) begin
                we           = 1'b1;
                waddr        = tomb_now;
                res_status_d = lpht_pkg::RSP_NEW;
              end else if (use_empty && fits) begin
                we           = 1'b1;
                fill_d       = fill_q + 1'b1;
                res_status_d = lpht_pkg::RSP_NEW;
              end else begin
                res_status_d = lpht_pkg::RSP_FULL;
              end
            end
            lpht_pkg::REQ_DEL: begin
              wdata.state = lpht_pkg::SLOT_TOMB;
              wdata.key   = rdata_q.key;
              wdata.value = rdata_q.value;
              if (found) begin
                we           = 1'b1;
                res_status_d = lpht_pkg::RSP_OK;
              end
            end
            default: begin
            end
          endcase
        end else begin
          idx_d       = idx_inc;
          cnt_d       = cnt_q + 1'b1;
          tomb_d      = tomb_now;
          have_tomb_d = have_now;
        end
      end
      lpht_pkg::S_RESP: begin
        if (out_free) begin
          state_d = lpht_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lpht_pkg::S_IDLE;
      end
    endcase
  end

  // slot memory; outside the clear pass writes only close a request, and the
  // next probe read comes at least a hash reduction later: no forwarding needed
  always_ff @(posedge clk_i) begin
    if (we) begin
      slot_mem_q[waddr] <= wdata;
    end
    rdata_q <= slot_mem_q[idx_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lpht_pkg::S_CLEAR;
      idx_q        <= '0;
      cnt_q        <= '0;
      tomb_q       <= '0;
      have_tomb_q  <= 1'b0;
      fill_q       <= '0;
      limit_q      <= lpht_pkg::LOAD_LIMIT_RST;
      res_status_q <= lpht_pkg::RSP_MISS;
      res_value_q  <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      cnt_q        <= cnt_d;
      tomb_q       <= tomb_d;
      have_tomb_q  <= have_tomb_d;
      fill_q       <= fill_d;
      res_status_q <= res_status_d;
      res_value_q  <= res_value_d;
      if (cfg_i.valid && cfg_i.ready) begin
        limit_q <= cfg_i.load_limit;
      end
      if ((state_q == lpht_pkg::S_RESP) && out_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      req_q <= req_i.req_type;
      key_q <= req_i.key_id;
      val_q <= req_i.value_in;
    end
    if ((state_q == lpht_pkg::S_RESP) && out_free) begin
      rsp_status_q <= res_status_q;
      rsp_value_q  <= res_value_q;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = rsp_status_q;
  assign rsp_o.value_out = rsp_value_q;

  // fill count only grows, one slot per request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != $past(fill_q) |-> fill_q == $past(fill_q) + 1'b1)
    else $error("fill count moved by more than one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lpht_pkg::S_CLEAR |-> !req_i.ready)
    else $error("request taken during clearing pass");

  // a slot write ends the probe, the result cycle follows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we && state_q != lpht_pkg::S_CLEAR |=> state_q == lpht_pkg::S_RESP)
    else $error("slot write outside the end of a probe");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == lpht_pkg::S_RESP))
    else $error("result loaded outside the result cycle");

endmodule

>>> rtl/lpht_hash_mod.sv
// ----------------------------------------------------------------------------
// lpht_hash_mod
// Reduces a 32-bit hash modulo SLOTS, one byte of the hash per cycle.
// ----------------------------------------------------------------------------
module lpht_hash_mod #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lpht_pkg::HASH_W-1:0] hash_i,
  output logic                        done_o,
  output logic [$clog2(SLOTS)-1:0]    idx_o
);

  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned DIGIT  = 8;
  localparam int unsigned STEPS  = lpht_pkg::HASH_W / DIGIT;
  localparam int unsigned STEP_W = $clog2(STEPS);
  localparam logic [IDX_W:0] SlotsW = (IDX_W + 1)'(SLOTS);

  logic                        busy_q;
  logic [STEP_W-1:0]           step_q;
  logic [lpht_pkg::HASH_W-1:0] sh_q;
  logic [IDX_W-1:0]            rem_q, rem_d;

  // restoring reduction: remainder stays below SLOTS, so one subtract per bit
  always_comb begin
    logic [IDX_W:0] r;
    r = {1'b0, rem_q};
    for (int i = 0; i < DIGIT; i++) begin
      r = {r[IDX_W-1:0], sh_q[lpht_pkg::HASH_W-1-i]};
      if (r >= SlotsW) begin
        r = r - SlotsW;
      end
    end
    rem_d = r[IDX_W-1:0];
  end

  assign done_o = busy_q && (step_q == STEP_W'(STEPS - 1));
  assign idx_o  = rem_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      busy_q <= !done_o;
      step_q <= step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= hash_i;
      rem_q <= '0;
    end else if (busy_q) begin
      sh_q  <= sh_q << DIGIT;
      rem_q <= rem_d;
    end
  end

endmodule
